// ===== src/sorted_priority_queue_top_macros.svh =====
// Assertion macros for the sorted priority queue.
// Each takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT_NOW(label, clk, rst_n, cond, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) \
		else $error(msg);

`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rhs)) \
		else $error(msg);

`else

`define SPQ_ASSERT_NOW(label, clk, rst_n, cond, rhs, msg)

`define SPQ_ASSERT_NEXT(label, clk, rst_n, cond, rhs, msg)

`endif

`endif

// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int VALUE_W         = 32;
	localparam int PRIO_W          = 8;
	localparam int STATUS_W        = 2;
	localparam int OCC_W           = 5;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} spq_entry_t;

	// Broadcast to every cell in the cycle a transaction is accepted
	typedef struct packed {
		logic       enq;
		logic       deq;
		spq_entry_t entry;
	} spq_cmd_t;

endpackage

// ===== src/spq_if.sv =====
`timescale 1ns / 1ps

interface spq_in_if
	import spq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               op;
	logic [VALUE_W-1:0] value;
	logic [PRIO_W-1:0]  priority_req;

	modport source (output valid, output op, output value, output priority_req, input ready);
	modport sink   (input valid, input op, input value, input priority_req, output ready);
endinterface

interface spq_out_if
	import spq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  head_value;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, output head_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input head_value, input status, input occupancy,
		output ready);
endinterface

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occupied,
	input  logic       left_gt,
	input  spq_entry_t left_entry,
	input  spq_entry_t right_entry,
	output logic       gt,
	output spq_entry_t entry
);

	spq_entry_t entry_q;

	// An empty cell counts as holding a larger number, so it takes part in the shift
	assign gt    = !occupied || (entry_q.prio > cmd.entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.enq && gt) begin
			entry_q <= left_gt ? left_entry : cmd.entry;
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ===== src/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// An accepted transaction's result is registered on the output in the cycle after it is accepted.
// Throughput: one transaction per cycle; every cell compares and shifts in parallel.
// A stalled result holds the input back until it is taken.
// Reset (arst_n low, asynchronous) empties the queue and drops any pending result;
// the cell contents are not cleared.

`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic                out_valid_q;
	logic [VALUE_W-1:0]  head_value_q;
	spq_status_t         status_q;
	logic [OCC_W-1:0]    occupancy_q;

	logic        accept;
	logic        full;
	logic        empty;
	spq_cmd_t    cmd;
	spq_status_t status_next;
	logic [VALUE_W-1:0] head_next;

	logic       cell_gt    [QUEUE_DEPTH];
	spq_entry_t cell_entry [QUEUE_DEPTH];

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign cmd.enq         = accept && (req.op == OP_ENQ) && !full;
	assign cmd.deq         = accept && (req.op == OP_DEQ) && !empty;
	assign cmd.entry.value = req.value;
	assign cmd.entry.prio  = req.priority_req;

	always_comb begin
		count_next  = count_q;
		status_next = ST_DONE;
		head_next   = '0;
		if (req.op == OP_ENQ) begin
			if (full) begin
				status_next = ST_FULL;
			end else begin
				count_next = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_next = ST_EMPTY;
				head_next   = '1;
			end else begin
				count_next = count_q - 1'b1;
				head_next  = cell_entry[0].value;
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic       left_gt;
		spq_entry_t left_entry;
		spq_entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_gt    = 1'b0;
			assign left_entry = cmd.entry;
		end else begin : g_body
			assign left_gt    = cell_gt[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (count_q > CNT_W'(i)),
			.left_gt     (left_gt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.gt          (cell_gt[i]),
			.entry       (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_value_q <= head_next;
			status_q     <= status_next;
			occupancy_q  <= OCC_W'(count_next);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.head_value = head_value_q;
	assign rsp.status     = status_q;
	assign rsp.occupancy  = occupancy_q;

	`SPQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "occupancy beyond depth")
	`SPQ_ASSERT_NEXT(a_result_after_accept, clk, arst_n, accept, out_valid_q, "no result after accepted transaction")
	`SPQ_ASSERT_NEXT(a_enq_grows, clk, arst_n, cmd.enq, count_q == $past(count_q) + 1'b1, "enqueue did not grow the queue")
	`SPQ_ASSERT_NEXT(a_drop_keeps, clk, arst_n, accept && !cmd.enq && !cmd.deq, $stable(count_q), "rejected transaction changed occupancy")
	`SPQ_ASSERT_NOW(a_empty_result, clk, arst_n, out_valid_q && status_q == ST_EMPTY, head_value_q == '1 && occupancy_q == '0, "empty dequeue result malformed")

endmodule
